>>> hw/rtl/tdqs_pkg.sv
// Shared types and codes of the tick delay queue server.
`timescale 1ns / 1ps

package tdqs_pkg;

  localparam logic [1:0] MODE_TICK = 2'd0;
  localparam logic [1:0] MODE_TIME = 2'd1;
  localparam logic [1:0] MODE_ABS  = 2'd2;
  localparam logic [1:0] MODE_REL  = 2'd3;

  localparam logic [1:0] KIND_ACK     = 2'd0;
  localparam logic [1:0] KIND_TIME    = 2'd1;
  localparam logic [1:0] KIND_RELEASE = 2'd2;
  localparam logic [1:0] KIND_FULL    = 2'd3;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_ACK,
    ST_REL
  } state_t;

  typedef struct packed {
    logic       latch;
    logic       tick_inc;
    logic       emit;
    logic [1:0] kind;
    logic       from_head;
    logic       last_bit;
    logic       insert;
    logic       pop;
  } cmd_t;

  typedef struct packed {
    logic [1:0] mode;
    logic       past;
    logic       full;
    logic       due;
    logic       next_due;
    logic       out_free;
  } status_t;

endpackage

>>> hw/rtl/tick_delay_queue_server.sv
// Top level of the tick delay queue server.
//
// The input channel takes one request word at a time: a tick, a time query,
// a delay until an absolute tick, or a delay by a relative tick count.
// The result channel returns reply words; out_last marks the final word
// that belongs to a request.
// A request is taken only while the block is idle. A time query, a delay
// released at once and a queue full reply are latched in the idle state and
// enter the output register from the execute state once it is free, and then the
// block is idle again; a stored delay is inserted in the execute state, with no word.
// A tick advances the count in the execute state, its acknowledgement enters
// the output register from the ack state and each release follows from the
// release state, one word at a time while the output register is free;
// the waiter row is kept sorted on insertion, so the earliest waiter sits at its head.
// The reply stage is one output register; when the receiver stalls, the
// controller waits in place and the word in that register holds.
// Reset clears the tick count, the waiter count and the output valid flag.
`timescale 1ns / 1ps

module tick_delay_queue_server #(
  parameter int MAX_WAITERS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_mode,
  input  logic [7:0]  in_task_id,
  input  logic [31:0] in_time_value,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_reply_kind,
  output logic [7:0]  out_reply_task,
  output logic [31:0] out_reply_time,
  output logic        out_last
);

  tdqs_pkg::cmd_t    cmd;
  tdqs_pkg::status_t sts;

  tdqs_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  tdqs_dpath #(
    .MAX_WAITERS (MAX_WAITERS)
  ) u_dpath (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_mode        (in_mode),
    .in_task_id     (in_task_id),
    .in_time_value  (in_time_value),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_reply_kind (out_reply_kind),
    .out_reply_task (out_reply_task),
    .out_reply_time (out_reply_time),
    .out_last       (out_last),
    .cmd            (cmd),
    .sts            (sts)
  );

endmodule

>>> hw/rtl/tdqs_ctrl.sv
// Controller state machine of the tick delay queue server.
`timescale 1ns / 1ps

module tdqs_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  tdqs_pkg::status_t sts,
  output tdqs_pkg::cmd_t   cmd
);

  tdqs_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= tdqs_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    in_ready  = 1'b0;
    cmd       = '0;
    unique case (state_r)
      tdqs_pkg::ST_IDLE: begin
        in_ready  = 1'b1;
        cmd.latch = in_valid;
        if (in_valid) begin
          state_nxt = tdqs_pkg::ST_EXEC;
        end
      end
      tdqs_pkg::ST_EXEC: begin
        unique case (sts.mode)
          tdqs_pkg::MODE_TICK: begin
            cmd.tick_inc = 1'b1;
            state_nxt    = tdqs_pkg::ST_ACK;
          end
          tdqs_pkg::MODE_TIME: begin
            if (sts.out_free) begin
              cmd.emit     = 1'b1;
              cmd.kind     = tdqs_pkg::KIND_TIME;
              cmd.last_bit = 1'b1;
              state_nxt    = tdqs_pkg::ST_IDLE;
            end
          end
          default: begin
            priority if (sts.mode == tdqs_pkg::MODE_ABS && sts.past) begin
              if (sts.out_free) begin
                cmd.emit     = 1'b1;
                cmd.kind     = tdqs_pkg::KIND_RELEASE;
                cmd.last_bit = 1'b1;
                state_nxt    = tdqs_pkg::ST_IDLE;
              end
            end else if (sts.full) begin
              if (sts.out_free) begin
                cmd.emit     = 1'b1;
                cmd.kind     = tdqs_pkg::KIND_FULL;
                cmd.last_bit = 1'b1;
                state_nxt    = tdqs_pkg::ST_IDLE;
              end
            end else begin
              cmd.insert = 1'b1;
              state_nxt  = tdqs_pkg::ST_IDLE;
            end
          end
        endcase
      end
      tdqs_pkg::ST_ACK: begin
        if (sts.out_free) begin
          cmd.emit     = 1'b1;
          cmd.kind     = tdqs_pkg::KIND_ACK;
          cmd.last_bit = !sts.due;
          state_nxt    = sts.due ? tdqs_pkg::ST_REL : tdqs_pkg::ST_IDLE;
        end
      end
      tdqs_pkg::ST_REL: begin
        if (sts.out_free) begin
          cmd.emit      = 1'b1;
          cmd.kind      = tdqs_pkg::KIND_RELEASE;
          cmd.from_head = 1'b1;
          cmd.pop       = 1'b1;
          cmd.last_bit  = !sts.next_due;
          state_nxt     = sts.next_due ? tdqs_pkg::ST_REL : tdqs_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = tdqs_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

>>> hw/rtl/tdqs_dpath.sv
// Datapath of the tick delay queue server: tick count, sorted waiter row, output register.
`timescale 1ns / 1ps

module tdqs_dpath #(
  parameter int MAX_WAITERS = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [1:0]        in_mode,
  input  logic [7:0]        in_task_id,
  input  logic [31:0]       in_time_value,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [1:0]        out_reply_kind,
  output logic [7:0]        out_reply_task,
  output logic [31:0]       out_reply_time,
  output logic              out_last,
  input  tdqs_pkg::cmd_t    cmd,
  output tdqs_pkg::status_t sts
);

  localparam int CW = $clog2(MAX_WAITERS + 1);

  logic [31:0]   tick_r;
  logic [CW-1:0] cnt_r;
  logic [1:0]    mode_r;
  logic [7:0]    task_r;
  logic [31:0]   deadline_r;
  logic [31:0]   dl_r [MAX_WAITERS];
  logic [7:0]    tk_r [MAX_WAITERS];
  logic [MAX_WAITERS-1:0] le;

  logic          out_valid_r;
  logic [1:0]    kind_r;
  logic [7:0]    rtask_r;
  logic [31:0]   rtime_r;
  logic          last_r;
  logic          next_due;

  // The row stays sorted by deadline; equal deadlines stay in arrival order.
  for (genvar i = 0; i < MAX_WAITERS; i++) begin : g_cell
    assign le[i] = (CW'(i) < cnt_r) && (dl_r[i] <= deadline_r);

    always_ff @(posedge clk) begin
      if (cmd.insert) begin
        if (!le[i]) begin
          if (i == 0) begin
            dl_r[i] <= deadline_r;
            tk_r[i] <= task_r;
          end else if (le[(i > 0) ? i - 1 : 0]) begin
            dl_r[i] <= deadline_r;
            tk_r[i] <= task_r;
          end else begin
            dl_r[i] <= dl_r[(i > 0) ? i - 1 : 0];
            tk_r[i] <= tk_r[(i > 0) ? i - 1 : 0];
          end
        end
      end else if (cmd.pop && i + 1 < MAX_WAITERS) begin
        dl_r[i] <= dl_r[(i + 1 < MAX_WAITERS) ? i + 1 : i];
        tk_r[i] <= tk_r[(i + 1 < MAX_WAITERS) ? i + 1 : i];
      end
    end
  end

  if (MAX_WAITERS > 1) begin : g_next
    assign next_due = (cnt_r > CW'(1)) && (dl_r[1] <= tick_r);
  end else begin : g_no_next
    assign next_due = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_r      <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.tick_inc) begin
        tick_r <= tick_r + 32'd1;
      end
      if (cmd.insert) begin
        cnt_r <= cnt_r + CW'(1);
      end else if (cmd.pop) begin
        cnt_r <= cnt_r - CW'(1);
      end
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      mode_r     <= in_mode;
      task_r     <= in_task_id;
      deadline_r <= (in_mode == tdqs_pkg::MODE_REL) ? tick_r + in_time_value : in_time_value;
    end
    if (cmd.emit) begin
      kind_r  <= cmd.kind;
      rtask_r <= cmd.from_head ? tk_r[0] : task_r;
      rtime_r <= tick_r;
      last_r  <= cmd.last_bit;
    end
  end

  always_comb begin
    sts.mode     = mode_r;
    sts.past     = deadline_r < tick_r;
    sts.full     = cnt_r == CW'(MAX_WAITERS);
    sts.due      = (cnt_r != '0) && (dl_r[0] <= tick_r);
    sts.next_due = next_due;
    sts.out_free = !out_valid_r || out_ready;
  end

  assign out_valid      = out_valid_r;
  assign out_reply_kind = kind_r;
  assign out_reply_task = rtask_r;
  assign out_reply_time = rtime_r;
  assign out_last       = last_r;

endmodule

>>> hw/rtl/tdqs_checker.sv
// Port-level assertions of the tick delay queue server and their bind.
`timescale 1ns / 1ps

module tdqs_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic [1:0]  in_mode,
  input logic [7:0]  in_task_id,
  input logic [31:0] in_time_value,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  out_reply_kind,
  input logic [7:0]  out_reply_task,
  input logic [31:0] out_reply_time,
  input logic        out_last
);

  a_reset_clears_out: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("Output valid after reset.");

  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_ready |=> in_valid && $stable(in_mode) &&
      $stable(in_task_id) && $stable(in_time_value))
    else $error("Waiting request word changed.");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_reply_kind) &&
      $stable(out_reply_task) && $stable(out_reply_time) && $stable(out_last))
    else $error("Stalled output word changed.");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("Request taken while the previous one is in progress.");

  a_busy_mid_burst: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |-> !in_ready)
    else $error("Idle while a reply burst is unfinished.");

endmodule

bind tick_delay_queue_server tdqs_checker u_tdqs_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_valid),
  .in_ready       (in_ready),
  .in_mode        (in_mode),
  .in_task_id     (in_task_id),
  .in_time_value  (in_time_value),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .out_reply_kind (out_reply_kind),
  .out_reply_task (out_reply_task),
  .out_reply_time (out_reply_time),
  .out_last       (out_last)
);

>>> dv/tb_tick_delay_queue_server.sv
// Self-checking testbench of the tick delay queue server, with its own predictor.
`timescale 1ns / 1ps

module tb_tick_delay_queue_server;

  localparam int MAX_WAITERS = 16;
  localparam int RANDOM_WORDS = 184;
  localparam int CYCLE_LIMIT = 200000;
  localparam int DRAIN_CYCLES = 40;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  dest;
    logic [31:0] stamp;
    logic        last;
  } reply_t;

  typedef struct packed {
    logic [1:0]  mode;
    logic [7:0]  id;
    logic [31:0] tv;
    logic        typed;
    logic [1:0]  exp_kind;
    logic [31:0] exp_stamp;
  } dir_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  in_mode = tdqs_pkg::MODE_TICK;
  logic [7:0]  in_task_id = 8'h00;
  logic [31:0] in_time_value = 32'h0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  out_reply_kind;
  logic [7:0]  out_reply_task;
  logic [31:0] out_reply_time;
  logic        out_last;

  logic [31:0] ticks_now;
  logic [31:0] wait_deadline [MAX_WAITERS];
  logic [7:0]  wait_dest [MAX_WAITERS];
  int          wait_count;

  reply_t fresh_replies [$];
  reply_t expected_replies [$];

  int errors = 0;
  int cycle_count = 0;
  int send_idle_pct = 0;
  int stall_pct = 0;
  int words_sent = 0;
  int replies_checked = 0;
  int full_replies = 0;
  int release_replies = 0;
  int burst_len = 0;
  int longest_burst = 0;

  // The fill rows all fall due by tick 3, so the tick after the full table
  // releases every waiter.
  dir_row_t directed_rows [26] = '{
    '{tdqs_pkg::MODE_TIME, 8'h00, 32'h0000_0000, 1'b1, tdqs_pkg::KIND_TIME, 32'd0},
    '{tdqs_pkg::MODE_TICK, 8'hFF, 32'h0000_0000, 1'b1, tdqs_pkg::KIND_ACK, 32'd1},
    '{tdqs_pkg::MODE_ABS, 8'h11, 32'h0000_0000, 1'b1, tdqs_pkg::KIND_RELEASE, 32'd1},
    '{tdqs_pkg::MODE_ABS, 8'h12, 32'h0000_0001, 1'b0, tdqs_pkg::KIND_ACK, 32'd0},
    '{tdqs_pkg::MODE_REL, 8'h13, 32'h0000_0000, 1'b0, tdqs_pkg::KIND_ACK, 32'd0},
    '{tdqs_pkg::MODE_REL, 8'h14, 32'hFFFF_FFFF, 1'b0, tdqs_pkg::KIND_ACK, 32'd0},
    '{tdqs_pkg::MODE_TICK, 8'hAA, 32'h0000_0000, 1'b0, tdqs_pkg::KIND_ACK, 32'd0},
    '{tdqs_pkg::MODE_REL, 8'h20, 32'h0000_0001, 1'b0, tdqs_pkg::KIND_ACK, 32'd0},
    '{tdqs_pkg::MODE_ABS, 8'h21, 32'h0000_0003, 1'b0, tdqs_pkg::KIND_ACK, 32'd0},
    '{tdqs_pkg::MODE_REL, 8'h22, 32'h0000_0000, 1'b0, tdqs_pkg::KIND_ACK, 32'd0},
    '{tdqs_pkg::MODE_ABS, 8'h23, 32'h0000_0002, 1'b0, tdqs_pkg::KIND_ACK, 32'd0},
    '{tdqs_pkg::MODE_REL, 8'h24, 32'h0000_0001, 1'b0, tdqs_pkg::KIND_ACK, 32'd0},
    '{tdqs_pkg::MODE_ABS, 8'h25, 32'h0000_0003, 1'b0, tdqs_pkg::KIND_ACK, 32'd0},
    '{tdqs_pkg::MODE_REL, 8'h26, 32'h0000_0000, 1'b0, tdqs_pkg::KIND_ACK, 32'd0},
    '{tdqs_pkg::MODE_ABS, 8'h27, 32'h0000_0003, 1'b0, tdqs_pkg::KIND_ACK, 32'd0},
    '{tdqs_pkg::MODE_REL, 8'h28, 32'h0000_0001, 1'b0, tdqs_pkg::KIND_ACK, 32'd0},
    '{tdqs_pkg::MODE_ABS, 8'h29, 32'h0000_0002, 1'b0, tdqs_pkg::KIND_ACK, 32'd0},
    '{tdqs_pkg::MODE_REL, 8'h2A, 32'h0000_0001, 1'b0, tdqs_pkg::KIND_ACK, 32'd0},
    '{tdqs_pkg::MODE_ABS, 8'h2B, 32'h0000_0003, 1'b0, tdqs_pkg::KIND_ACK, 32'd0},
    '{tdqs_pkg::MODE_REL, 8'h2C, 32'h0000_0000, 1'b0, tdqs_pkg::KIND_ACK, 32'd0},
    '{tdqs_pkg::MODE_ABS, 8'h2D, 32'h0000_0003, 1'b0, tdqs_pkg::KIND_ACK, 32'd0},
    '{tdqs_pkg::MODE_REL, 8'h2E, 32'h0000_0001, 1'b0, tdqs_pkg::KIND_ACK, 32'd0},
    '{tdqs_pkg::MODE_ABS, 8'h2F, 32'h0000_0003, 1'b0, tdqs_pkg::KIND_ACK, 32'd0},
    '{tdqs_pkg::MODE_REL, 8'h30, 32'h0000_0005, 1'b1, tdqs_pkg::KIND_FULL, 32'd2},
    '{tdqs_pkg::MODE_ABS, 8'h31, 32'hFFFF_FFFF, 1'b1, tdqs_pkg::KIND_FULL, 32'd2},
    '{tdqs_pkg::MODE_TICK, 8'h55, 32'h0000_0000, 1'b0, tdqs_pkg::KIND_ACK, 32'd0}
  };

  tick_delay_queue_server #(
    .MAX_WAITERS(MAX_WAITERS)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_mode(in_mode),
    .in_task_id(in_task_id),
    .in_time_value(in_time_value),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_reply_kind(out_reply_kind),
    .out_reply_task(out_reply_task),
    .out_reply_time(out_reply_time),
    .out_last(out_last)
  );

  always #5 clk = ~clk;

  function automatic void add_reply(logic [1:0] kind, logic [7:0] dest, logic last);
    reply_t r;
    r.kind = kind;
    r.dest = dest;
    r.stamp = ticks_now;
    r.last = last;
    fresh_replies.push_back(r);
  endfunction

  function automatic void park_waiter(logic [31:0] deadline, logic [7:0] id);
    if (wait_count >= MAX_WAITERS) begin
      add_reply(tdqs_pkg::KIND_FULL, id, 1'b1);
    end else begin
      wait_deadline[wait_count] = deadline;
      wait_dest[wait_count] = id;
      wait_count++;
    end
  endfunction

  function automatic void compute_replies(logic [1:0] mode, logic [7:0] id, logic [31:0] tv);
    int best;
    fresh_replies.delete();
    unique case (mode)
      tdqs_pkg::MODE_TICK: begin
        ticks_now = ticks_now + 32'd1;
        add_reply(tdqs_pkg::KIND_ACK, id, 1'b0);
        forever begin
          best = -1;
          for (int i = 0; i < wait_count; i++) begin
            if (wait_deadline[i] <= ticks_now &&
                (best < 0 || wait_deadline[i] < wait_deadline[best])) begin
              best = i;
            end
          end
          if (best < 0) break;
          add_reply(tdqs_pkg::KIND_RELEASE, wait_dest[best], 1'b0);
          for (int i = best; i + 1 < wait_count; i++) begin
            wait_deadline[i] = wait_deadline[i + 1];
            wait_dest[i] = wait_dest[i + 1];
          end
          wait_count--;
        end
        fresh_replies[fresh_replies.size() - 1].last = 1'b1;
      end
      tdqs_pkg::MODE_TIME: add_reply(tdqs_pkg::KIND_TIME, id, 1'b1);
      tdqs_pkg::MODE_ABS: begin
        if (tv < ticks_now) add_reply(tdqs_pkg::KIND_RELEASE, id, 1'b1);
        else park_waiter(tv, id);
      end
      default: park_waiter(ticks_now + tv, id);
    endcase
  endfunction

  task automatic send_request(dir_row_t row);
    reply_t typed_reply;
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_mode <= row.mode;
    in_task_id <= row.id;
    in_time_value <= row.tv;
    do @(posedge clk); while (!in_ready);
    compute_replies(row.mode, row.id, row.tv);
    words_sent++;
    if (row.typed) begin
      typed_reply.kind = row.exp_kind;
      typed_reply.dest = row.id;
      typed_reply.stamp = row.exp_stamp;
      typed_reply.last = 1'b1;
      expected_replies.push_back(typed_reply);
    end else begin
      foreach (fresh_replies[i]) expected_replies.push_back(fresh_replies[i]);
    end
  endtask

  function automatic dir_row_t random_request();
    dir_row_t row;
    int pick;
    row = '0;
    row.id = 8'($urandom);
    pick = $urandom_range(99);
    if (pick < 30) begin
      row.mode = tdqs_pkg::MODE_TICK;
      row.tv = $urandom;
    end else if (pick < 40) begin
      row.mode = tdqs_pkg::MODE_TIME;
      row.tv = $urandom;
    end else if (pick < 70) begin
      row.mode = tdqs_pkg::MODE_ABS;
      if ($urandom_range(31) == 0) row.tv = $urandom;
      else if ($urandom_range(3) == 0 && ticks_now != 0)
        row.tv = ticks_now - $urandom_range(1, ticks_now < 4 ? ticks_now : 4);
      else row.tv = ticks_now + $urandom_range(0, 8);
    end else begin
      row.mode = tdqs_pkg::MODE_REL;
      pick = $urandom_range(31);
      if (pick == 0) row.tv = $urandom;
      else if (pick < 4 && ticks_now >= 3) row.tv = 32'hFFFF_FFFF - $urandom_range(0, 2);
      else row.tv = $urandom_range(0, 6);
    end
    return row;
  endfunction

  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk) begin
    reply_t exp;
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end else if (rst_n && out_valid && out_ready) begin
      if (expected_replies.size() == 0) begin
        $error("reply word with nothing expected: kind %0d task %0h time %0d",
               out_reply_kind, out_reply_task, out_reply_time);
        errors++;
      end else begin
        exp = expected_replies.pop_front();
        if (out_reply_kind !== exp.kind) begin
          $error("reply_kind: expected %0d, got %0d", exp.kind, out_reply_kind);
          errors++;
        end
        if (out_reply_task !== exp.dest) begin
          $error("reply_task: expected %0h, got %0h", exp.dest, out_reply_task);
          errors++;
        end
        if (out_reply_time !== exp.stamp) begin
          $error("reply_time: expected %0d, got %0d", exp.stamp, out_reply_time);
          errors++;
        end
        if (out_last !== exp.last) begin
          $error("last: expected %0d, got %0d", exp.last, out_last);
          errors++;
        end
      end
      replies_checked++;
      if (out_reply_kind == tdqs_pkg::KIND_FULL) full_replies++;
      if (out_reply_kind == tdqs_pkg::KIND_RELEASE) release_replies++;
      burst_len++;
      if (out_last) begin
        if (burst_len > longest_burst) longest_burst = burst_len;
        burst_len = 0;
      end
    end
  end

  initial begin
    ticks_now = 32'd0;
    wait_count = 0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i]) send_request(directed_rows[i]);

    for (int phase = 0; phase < 4; phase++) begin
      unique case (phase)
        0: begin send_idle_pct = 0; stall_pct = 0; end
        1: begin send_idle_pct = 56; stall_pct = 0; end
        2: begin send_idle_pct = 0; stall_pct = 56; end
        default: begin send_idle_pct = 7; stall_pct = 7; end
      endcase
      for (int n = 0; n < RANDOM_WORDS / 4; n++) send_request(random_request());
    end

    @(negedge clk);
    in_valid <= 1'b0;
    wait (expected_replies.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (expected_replies.size() != 0) begin
      $error("%0d expected reply words never arrived", expected_replies.size());
      errors++;
    end

    $display("Sent %0d requests under four idle and stall mixes; checked %0d reply words.",
             words_sent, replies_checked);
    $display("Saw %0d releases, %0d queue full replies, longest reply burst %0d words.",
             release_replies, full_replies, longest_burst);
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
